// File: hw/rtl/hst_pkg.sv
// ----------------------------------------------------------------------------
// hst_pkg
// Shared types and constants for the handle slot table.
// ----------------------------------------------------------------------------
package hst_pkg;

  // Table geometry. Handles are 7-bit signed, so at most 64 slots are usable.
  localparam int SLOT_COUNT   = 64;
  localparam int USABLE_SLOTS = (SLOT_COUNT < 64) ? SLOT_COUNT : 64;
  localparam int IDX_W        = $clog2(USABLE_SLOTS);

  // Free-slot scan: one group of lanes is examined per cycle.
  localparam int SCAN_LANES  = 8;
  localparam int LANE_W      = $clog2(SCAN_LANES);
  localparam int SCAN_GROUPS = (USABLE_SLOTS + SCAN_LANES - 1) / SCAN_LANES;
  localparam int SCAN_PAD    = SCAN_GROUPS * SCAN_LANES;
  localparam int GRP_W       = (SCAN_GROUPS > 1) ? $clog2(SCAN_GROUPS) : 1;

  localparam int WORD_W   = 64;
  localparam int HANDLE_W = 7;
  localparam logic [HANDLE_W-1:0] NIL_HANDLE = 7'h7F;

  // Stream payload widths (padded to whole bytes).
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 80;

  typedef enum logic [1:0] {
    REQ_ACQUIRE    = 2'd0,
    REQ_RELEASE    = 2'd1,
    REQ_LOOKUP     = 2'd2,
    REQ_INVALIDATE = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    SLOT_FREE      = 2'd0,
    SLOT_LOCKED    = 2'd1,
    SLOT_HELD      = 2'd2,
    SLOT_COLLECTED = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    CODE_OK       = 2'd0,
    CODE_NIL      = 2'd1,
    CODE_FULL     = 2'd2,
    CODE_NOTFOUND = 2'd3
  } result_code_t;

  // Write command into the slot store.
  typedef struct packed {
    logic              set;      // mark slot in use and write its state
    logic              clr;      // return slot to free
    logic              word_en;  // also write the object word
    logic [IDX_W-1:0]  idx;
    slot_state_t       state;
    logic [WORD_W-1:0] word;
  } hst_wr_t;

  // Registered read data from the slot store.
  typedef struct packed {
    slot_state_t       state;
    logic [WORD_W-1:0] word;
  } hst_rd_t;

  // Scanner status toward the sequencer.
  typedef struct packed {
    logic             hit;
    logic             last;
    logic [IDX_W-1:0] idx;
  } hst_scan_t;

endpackage

// File: hw/rtl/hst_store.sv
// ----------------------------------------------------------------------------
// hst_store
// Slot state and object word memories with per-slot in-use bits.
// ----------------------------------------------------------------------------
module hst_store (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  rd_en,
  input  logic [hst_pkg::IDX_W-1:0]             rd_idx,
  output hst_pkg::hst_rd_t                      rd,
  input  hst_pkg::hst_wr_t                      wr,
  output logic [hst_pkg::USABLE_SLOTS-1:0]      used
);

  hst_pkg::slot_state_t             state_mem [hst_pkg::USABLE_SLOTS];
  logic [hst_pkg::WORD_W-1:0]       word_mem  [hst_pkg::USABLE_SLOTS];
  hst_pkg::slot_state_t             state_q;
  logic [hst_pkg::WORD_W-1:0]       word_q;
  logic                             used_q;

  // In-use bits: a slot not in use reads as free.
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr.set) begin
      used[wr.idx] <= 1'b1;
    end else if (wr.clr) begin
      used[wr.idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      state_mem[wr.idx] <= wr.state;
    end
    if (wr.set && wr.word_en) begin
      word_mem[wr.idx] <= wr.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      state_q <= state_mem[rd_idx];
      word_q  <= word_mem[rd_idx];
      used_q  <= used[rd_idx];
    end
  end

  assign rd.state = used_q ? state_q : hst_pkg::SLOT_FREE;
  assign rd.word  = word_q;

endmodule

// File: hw/rtl/hst_scan.sv
// ----------------------------------------------------------------------------
// hst_scan
// Lowest-free-slot search, one group of lanes per cycle while advance is asserted.
// ----------------------------------------------------------------------------
module hst_scan (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic                                  advance,
  input  logic [hst_pkg::USABLE_SLOTS-1:0]      used,
  output hst_pkg::hst_scan_t                    status
);

  logic [hst_pkg::GRP_W-1:0]      grp;
  logic [hst_pkg::SCAN_PAD-1:0]   used_pad;
  logic [hst_pkg::SCAN_LANES-1:0] lanes;
  logic [hst_pkg::LANE_W-1:0]     off;
  logic                           hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      grp <= '0;
    end else if (start) begin
      grp <= '0;
    end else if (advance) begin
      grp <= grp + 1'b1;
    end
  end

  always_comb begin
    // Lanes past the end of the table look busy.
    used_pad = '1;
    used_pad[hst_pkg::USABLE_SLOTS-1:0] = used;
    lanes = used_pad[grp*hst_pkg::SCAN_LANES +: hst_pkg::SCAN_LANES];
    hit = 1'b0;
    off = '0;
    for (int i = hst_pkg::SCAN_LANES - 1; i >= 0; i--) begin
      if (!lanes[i]) begin
        hit = 1'b1;
        off = hst_pkg::LANE_W'(i);
      end
    end
  end

  assign status.hit  = hit;
  assign status.last = (grp == hst_pkg::GRP_W'(hst_pkg::SCAN_GROUPS - 1));
  assign status.idx  = hst_pkg::IDX_W'({grp, off});

endmodule

// File: hw/rtl/handle_slot_table.sv
// ----------------------------------------------------------------------------
// handle_slot_table
// Handle table for stored object words: acquire, release, lookup, invalidate.
// ----------------------------------------------------------------------------
// One request item in, one result item out. The block takes one item at a
// time: release, lookup and invalidate pass from accept to the output
// register through accept with memory read, evaluate and deliver, or skip
// the evaluate step when the handle is nil or out of range. An acquire
// scans the in-use bits eight slots per cycle for the lowest free slot,
// then delivers; a nil acquire goes straight to delivery. The output
// register lets the next item be accepted while a result waits to be
// taken. After reset all slots are free at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module handle_slot_table (
  input  logic                          clk,
  input  logic                          rst,
  // Request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [63:0] object_word, [64] object_is_nil, [65] want_lock,
  // [72:66] slot_handle, [73] object_marked, [79:74] zero
  input  logic [hst_pkg::S_DATA_W-1:0]  s_tdata,
  // [1:0] req_type
  input  logic [1:0]                    s_tuser,
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [6:0] result_handle, [70:7] result_word, [72:71] slot_state_out,
  // [79:73] zero
  output logic [hst_pkg::M_DATA_W-1:0]  m_tdata,
  // [1:0] result_code
  output logic [1:0]                    m_tuser
);

  typedef enum logic [3:0] {
    FSM_IDLE = 4'b0001,
    FSM_SCAN = 4'b0010,
    FSM_EVAL = 4'b0100,
    FSM_FIN  = 4'b1000
  } fsm_t;

  fsm_t fsm, fsm_next;

  // Latched request
  hst_pkg::req_type_t                 req;
  logic [hst_pkg::WORD_W-1:0]         req_word;
  logic                               req_lock;
  logic [hst_pkg::HANDLE_W-1:0]       req_handle;
  logic                               req_marked;

  // Pending result
  logic [hst_pkg::HANDLE_W-1:0]       res_handle, res_handle_next;
  logic [hst_pkg::WORD_W-1:0]         res_word, res_word_next;
  hst_pkg::result_code_t              res_code, res_code_next;
  hst_pkg::slot_state_t               res_state, res_state_next;

  // Output register
  logic [hst_pkg::HANDLE_W-1:0]       out_handle;
  logic [hst_pkg::WORD_W-1:0]         out_word;
  hst_pkg::result_code_t              out_code;
  hst_pkg::slot_state_t               out_state;

  // Incoming fields
  hst_pkg::req_type_t                 in_req;
  logic [hst_pkg::WORD_W-1:0]         in_word;
  logic                               in_nil;
  logic                               in_lock;
  logic [hst_pkg::HANDLE_W-1:0]       in_handle;
  logic                               in_marked;
  logic                               in_handle_nil;
  logic                               in_handle_bad;

  logic                               accept;
  logic                               load_out;
  logic                               rd_en;
  logic                               scan_start;
  logic                               scan_advance;
  hst_pkg::hst_wr_t                   wr;
  hst_pkg::hst_rd_t                   rd;
  hst_pkg::hst_scan_t                 scan;
  logic [hst_pkg::USABLE_SLOTS-1:0]   used;
  hst_pkg::slot_state_t               acq_state;

  assign in_req    = hst_pkg::req_type_t'(s_tuser);
  assign in_word   = s_tdata[63:0];
  assign in_nil    = s_tdata[64];
  assign in_lock   = s_tdata[65];
  assign in_handle = s_tdata[72:66];
  assign in_marked = s_tdata[73];

  // Handle -1 is nil; any other negative or too large handle is not found.
  assign in_handle_nil = (in_handle == hst_pkg::NIL_HANDLE);
  assign in_handle_bad = in_handle[hst_pkg::HANDLE_W-1] ||
                         ({1'b0, in_handle} >= 8'(hst_pkg::USABLE_SLOTS));

  assign s_tready = (fsm == FSM_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign load_out = (fsm == FSM_FIN) && (!m_tvalid || m_tready);

  // Read the addressed slot as the item is taken; data is ready in EVAL.
  assign rd_en = accept && (in_req != hst_pkg::REQ_ACQUIRE) &&
                 !in_handle_nil && !in_handle_bad;

  assign acq_state = req_lock ? hst_pkg::SLOT_LOCKED : hst_pkg::SLOT_HELD;

  hst_store u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (rd_en),
    .rd_idx (in_handle[hst_pkg::IDX_W-1:0]),
    .rd     (rd),
    .wr     (wr),
    .used   (used)
  );

  hst_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .start   (scan_start),
    .advance (scan_advance),
    .used    (used),
    .status  (scan)
  );

  // Sequencer
  always_comb begin
    fsm_next        = fsm;
    res_handle_next = res_handle;
    res_word_next   = res_word;
    res_code_next   = res_code;
    res_state_next  = res_state;
    scan_start      = 1'b0;
    scan_advance    = 1'b0;
    wr              = '0;
    wr.idx          = req_handle[hst_pkg::IDX_W-1:0];
    wr.word         = req_word;
    case (fsm)
      FSM_IDLE: begin
        if (accept) begin
          res_word_next  = '0;
          res_state_next = hst_pkg::SLOT_FREE;
          if (in_req == hst_pkg::REQ_ACQUIRE) begin
            if (in_nil) begin
              res_handle_next = hst_pkg::NIL_HANDLE;
              res_code_next   = hst_pkg::CODE_NIL;
              fsm_next        = FSM_FIN;
            end else begin
              scan_start = 1'b1;
              fsm_next   = FSM_SCAN;
            end
          end else if (in_handle_nil) begin
            res_handle_next = in_handle;
            res_code_next   = hst_pkg::CODE_NIL;
            fsm_next        = FSM_FIN;
          end else if (in_handle_bad) begin
            res_handle_next = in_handle;
            res_code_next   = hst_pkg::CODE_NOTFOUND;
            fsm_next        = FSM_FIN;
          end else begin
            res_handle_next = in_handle;
            fsm_next        = FSM_EVAL;
          end
        end
      end
      FSM_SCAN: begin
        if (scan.hit) begin
          // Claim the lowest free slot.
          wr.set          = 1'b1;
          wr.word_en      = 1'b1;
          wr.idx          = scan.idx;
          wr.state        = acq_state;
          res_handle_next = hst_pkg::HANDLE_W'(scan.idx);
          res_code_next   = hst_pkg::CODE_OK;
          res_state_next  = acq_state;
          fsm_next        = FSM_FIN;
        end else if (scan.last) begin
          res_handle_next = hst_pkg::NIL_HANDLE;
          res_code_next   = hst_pkg::CODE_FULL;
          fsm_next        = FSM_FIN;
        end else begin
          scan_advance = 1'b1;
        end
      end
      FSM_EVAL: begin
        fsm_next       = FSM_FIN;
        res_code_next  = hst_pkg::CODE_OK;
        res_state_next = rd.state;
        case (req)
          hst_pkg::REQ_RELEASE: begin
            wr.clr         = 1'b1;
            res_state_next = hst_pkg::SLOT_FREE;
          end
          hst_pkg::REQ_LOOKUP: begin
            if (rd.state == hst_pkg::SLOT_LOCKED || rd.state == hst_pkg::SLOT_HELD) begin
              res_word_next = rd.word;
            end else begin
              res_code_next = hst_pkg::CODE_NOTFOUND;
            end
          end
          hst_pkg::REQ_INVALIDATE: begin
            // Collect a held slot whose object went unmarked.
            if (rd.state == hst_pkg::SLOT_HELD && !req_marked) begin
              wr.set         = 1'b1;
              wr.state       = hst_pkg::SLOT_COLLECTED;
              res_state_next = hst_pkg::SLOT_COLLECTED;
            end
          end
          default: begin
            res_state_next = hst_pkg::SLOT_FREE;
          end
        endcase
      end
      FSM_FIN: begin
        if (load_out) begin
          fsm_next = FSM_IDLE;
        end
      end
      default: begin
        fsm_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= FSM_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  // Hold the request for the later steps.
  always_ff @(posedge clk) begin
    if (accept) begin
      req        <= in_req;
      req_word   <= in_word;
      req_lock   <= in_lock;
      req_handle <= in_handle;
      req_marked <= in_marked;
    end
  end

  always_ff @(posedge clk) begin
    res_handle <= res_handle_next;
    res_word   <= res_word_next;
    res_code   <= res_code_next;
    res_state  <= res_state_next;
  end

  // Output register: advance on load, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_handle <= res_handle;
      out_word   <= res_word;
      out_code   <= res_code;
      out_state  <= res_state;
    end
  end

  assign m_tdata = {7'd0, out_state, out_word, out_handle};
  assign m_tuser = out_code;

endmodule
